// File: src/gcfb_pkg.sv
// Shared definitions for the gamma-correct frame blender.
// Holds operation codes, channel widths, ratio limits and the table write bundle.
// No dependencies.
package gcfb_pkg;

	typedef enum logic [1:0] {
		OP_BLEND  = 2'd0,
		OP_DEC_WR = 2'd1,
		OP_ENC_WR = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic SEL_NARROW = 1'b0;
	localparam logic SEL_WIDE   = 1'b1;

	localparam int NARROW_W = 5;
	localparam int WIDE_W   = 6;
	localparam int INDEX_W  = 6;
	localparam int RATIO_W  = 9;

	localparam logic [RATIO_W-1:0] RATIO_MIN   = 9'd128;
	localparam logic [RATIO_W-1:0] RATIO_MAX   = 9'd256;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd128;

	// One table write as seen by a lane.
	typedef struct packed {
		logic               dec_we;
		logic               enc_we;
		logic [INDEX_W-1:0] addr;
		logic [INDEX_W-1:0] data;
	} tbl_wr_t;

endpackage

// File: src/gcfb_ram.sv
// Generic RAM with one write port and one registered read port.
// No dependencies.
module gcfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/gcfb_lane.sv
// One color channel of the blender: decode lookup, weighted mix, encode lookup.
// Depends on gcfb_pkg and gcfb_ram.
module gcfb_lane #(
	parameter int W      = 5,
	parameter int LEVELS = 32
) (
	input  logic                 clk,
	input  gcfb_pkg::tbl_wr_t    wr,
	input  logic                 rd_en1,
	input  logic                 rd_en2,
	input  logic [W-1:0]         prev_ch,
	input  logic [W-1:0]         last_ch,
	input  logic [8:0]           w_last,
	input  logic [8:0]           w_prev,
	output logic [W-1:0]         result
);
	import gcfb_pkg::*;

	localparam int FULL  = 1 << W;
	localparam int DEPTH = (LEVELS < FULL) ? LEVELS : FULL;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = W + 9;

	logic          wr_ok;
	logic          prev_ok, last_ok, enc_ok;
	logic          prev_ok_s1, last_ok_s1, enc_ok_s2;
	logic [W-1:0]  dec_prev, dec_last, enc_data;
	logic [W-1:0]  lin_prev, lin_last, mixed;
	logic [MW-1:0] mix_sum;

	// Entries at or past the table depth are never stored and read as zero.
	assign wr_ok   = 9'(wr.addr) < 9'(DEPTH);
	assign prev_ok = 9'(prev_ch) < 9'(DEPTH);
	assign last_ok = 9'(last_ch) < 9'(DEPTH);

	gcfb_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_dec_prev (
		.clk(clk), .we(wr.dec_we && wr_ok), .waddr(wr.addr[AW-1:0]),
		.wdata(wr.data[W-1:0]), .re(rd_en1), .raddr(prev_ch[AW-1:0]), .rdata(dec_prev)
	);

	gcfb_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_dec_last (
		.clk(clk), .we(wr.dec_we && wr_ok), .waddr(wr.addr[AW-1:0]),
		.wdata(wr.data[W-1:0]), .re(rd_en1), .raddr(last_ch[AW-1:0]), .rdata(dec_last)
	);

	always_ff @(posedge clk) begin
		if (rd_en1) begin
			prev_ok_s1 <= prev_ok;
			last_ok_s1 <= last_ok;
		end
	end

	assign lin_prev = prev_ok_s1 ? dec_prev : '0;
	assign lin_last = last_ok_s1 ? dec_last : '0;

	// The weights sum to 256, so the rounded mix never exceeds the channel range.
	assign mix_sum = MW'(lin_prev) * MW'(w_prev) + MW'(lin_last) * MW'(w_last)
		+ MW'(128);
	assign mixed   = mix_sum[W+7:8];
	assign enc_ok  = 9'(mixed) < 9'(DEPTH);

	gcfb_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_enc (
		.clk(clk), .we(wr.enc_we && wr_ok), .waddr(wr.addr[AW-1:0]),
		.wdata(wr.data[W-1:0]), .re(rd_en2), .raddr(mixed[AW-1:0]), .rdata(enc_data)
	);

	always_ff @(posedge clk) begin
		if (rd_en2) begin
			enc_ok_s2 <= enc_ok;
		end
	end

	assign result = enc_ok_s2 ? enc_data : '0;

endmodule

// File: src/gamma_correct_frame_blend_core.sv
// Top level of the gamma-correct RGB565 frame blender.
// Depends on gcfb_pkg, gcfb_lane and gcfb_ram.
//
//   channel  signals                                   direction  moves
//   in       in_valid/in_ready, op, prev_pixel,        input      one command word
//            last_pixel, table_select, table_index,
//            table_value
//   out      out_valid/out_ready, blended_pixel        output     one blended pixel word
//   cfg      cfg_valid/cfg_ready, cfg_data             input      one blend ratio word
//
// The block accepts one word per clock while in_ready is high. In each lane a blend
// word passes a registered decode table read and then a registered encode table read.
// Table writes take effect at the edge that accepts them.
// Reset clears the pipeline valid flags and sets the ratio to 0.5; the tables hold
// nothing defined until software loads them. When out_ready is low the result waits
// in the output stage while the first stage may still take one more blend word.
module gamma_correct_frame_blend_core #(
	parameter int NARROW_LEVELS = 32,
	parameter int WIDE_LEVELS   = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [15:0]                 prev_pixel,
	input  logic [15:0]                 last_pixel,
	input  logic                        table_select,
	input  logic [gcfb_pkg::INDEX_W-1:0] table_index,
	input  logic [gcfb_pkg::INDEX_W-1:0] table_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [15:0]                 blended_pixel,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gcfb_pkg::RATIO_W-1:0] cfg_data
);
	import gcfb_pkg::*;

	logic               valid_s1, valid_s2;
	logic               adv1, adv2, accept, blend_acc;
	logic [RATIO_W-1:0] w_last_q, w_prev, ratio_clamped;
	tbl_wr_t            wr_narrow, wr_wide;
	logic [NARROW_W-1:0] red, blu;
	logic [WIDE_W-1:0]   grn;

	// The output stage moves when it is empty or its word is taken; the first
	// stage moves when it is empty or the output stage can take its word.
	assign adv2      = !valid_s2 || out_ready;
	assign adv1      = !valid_s1 || adv2;
	assign in_ready  = adv1;
	assign accept    = in_valid && in_ready;
	assign blend_acc = accept && (op_t'(op) == OP_BLEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= blend_acc;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid = valid_s2;

	// The ratio is clamped to 0.5..1.0 when written; the previous frame takes the rest.
	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data < RATIO_MIN) begin
			ratio_clamped = RATIO_MIN;
		end else if (cfg_data > RATIO_MAX) begin
			ratio_clamped = RATIO_MAX;
		end else begin
			ratio_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= RATIO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			w_last_q <= ratio_clamped;
		end
	end

	assign w_prev = RATIO_MAX - w_last_q;

	// Table writes go to every lane copy of the selected table pair.
	always_comb begin
		wr_narrow.dec_we = accept && (op_t'(op) == OP_DEC_WR) && (table_select == SEL_NARROW);
		wr_narrow.enc_we = accept && (op_t'(op) == OP_ENC_WR) && (table_select == SEL_NARROW);
		wr_narrow.addr   = table_index;
		wr_narrow.data   = table_value;
		wr_wide.dec_we   = accept && (op_t'(op) == OP_DEC_WR) && (table_select == SEL_WIDE);
		wr_wide.enc_we   = accept && (op_t'(op) == OP_ENC_WR) && (table_select == SEL_WIDE);
		wr_wide.addr     = table_index;
		wr_wide.data     = table_value;
	end

	gcfb_lane #(.W(NARROW_W), .LEVELS(NARROW_LEVELS)) u_red (
		.clk(clk), .wr(wr_narrow), .rd_en1(blend_acc), .rd_en2(adv2 && valid_s1),
		.prev_ch(prev_pixel[15:11]), .last_ch(last_pixel[15:11]),
		.w_last(w_last_q), .w_prev(w_prev), .result(red)
	);

	gcfb_lane #(.W(WIDE_W), .LEVELS(WIDE_LEVELS)) u_grn (
		.clk(clk), .wr(wr_wide), .rd_en1(blend_acc), .rd_en2(adv2 && valid_s1),
		.prev_ch(prev_pixel[10:5]), .last_ch(last_pixel[10:5]),
		.w_last(w_last_q), .w_prev(w_prev), .result(grn)
	);

	gcfb_lane #(.W(NARROW_W), .LEVELS(NARROW_LEVELS)) u_blu (
		.clk(clk), .wr(wr_narrow), .rd_en1(blend_acc), .rd_en2(adv2 && valid_s1),
		.prev_ch(prev_pixel[4:0]), .last_ch(last_pixel[4:0]),
		.w_last(w_last_q), .w_prev(w_prev), .result(blu)
	);

	// The three lane results are packed back into one RGB565 word.
	assign blended_pixel = {red, grn, blu};

endmodule
